// ===== sv/pfa_pkg.sv =====
package pfa_pkg;

  localparam int PAGE_W = 10;
  localparam int REG_W  = 11;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOT_USED = 2'd2
  } st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAM_PAGES   = 3'd0,
    REG_BIOS_BASE   = 3'd1,
    REG_BIOS_TOP    = 3'd2,
    REG_KERNEL_BASE = 3'd3,
    REG_KERNEL_TOP  = 3'd4
  } reg_idx_t;

  localparam logic [REG_W-1:0] RST_RAM_PAGES   = 11'd1024;
  localparam logic [REG_W-1:0] RST_BIOS_BASE   = 11'd160;
  localparam logic [REG_W-1:0] RST_BIOS_TOP    = 11'd256;
  localparam logic [REG_W-1:0] RST_KERNEL_BASE = 11'd256;
  localparam logic [REG_W-1:0] RST_KERNEL_TOP  = 11'd512;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_FINISH = 2'd1,
    S_WALK   = 2'd2
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [PAGE_W-1:0]  page_number;
  } item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  granted_page;
    st_t                status;
  } result_t;

  typedef struct packed {
    logic accept;
    logic walk_step;
    logic finish;
  } ctl_t;

endpackage

// ===== sv/pfa_ctrl.sv =====
module pfa_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  pfa_pkg::op_t operation,
  input  logic         walk_done,
  output logic         busy,
  output pfa_pkg::ctl_t ctl
);
  import pfa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (operation == OP_INIT) ? S_WALK : S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    ctl.accept    = 1'b0;
    ctl.walk_step = 1'b0;
    ctl.finish    = 1'b0;
    case (state)
      S_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
      end
      S_WALK: begin
        ctl.walk_step = !walk_done;
        ctl.finish    = walk_done;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/pfa_datapath.sv =====
module pfa_datapath #(
  parameter int MAX_PAGES = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pfa_pkg::ctl_t                      ctl,
  input  pfa_pkg::item_t                     item,
  input  logic                               cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfa_pkg::REG_W-1:0]          cfg_data,
  output logic                               walk_done,
  output logic                               done,
  output pfa_pkg::result_t                   result
);
  import pfa_pkg::*;

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);

  logic [REG_W-1:0] ram_pages;
  logic [REG_W-1:0] bios_base;
  logic [REG_W-1:0] bios_top;
  logic [REG_W-1:0] kern_base;
  logic [REG_W-1:0] kern_top;

  op_t           op_q;
  logic [IW-1:0] page_q;
  logic          page_ok_q;
  logic [CW-1:0] count;
  logic [CW-1:0] cursor;
  logic [CW-1:0] limit;

  logic [IW-1:0] stack_mem [MAX_PAGES];
  logic          map_mem   [MAX_PAGES];
  logic [IW-1:0] stack_rd;
  logic          map_rd;

  logic [31:0]   page_in32;
  logic [31:0]   ram32;
  logic [31:0]   cur32;
  logic [IW-1:0] page_idx;
  logic          page_ok;
  logic [CW-1:0] walk_lim;
  logic          reserved;
  logic          empty;
  logic          used;

  logic          map_we;
  logic [IW-1:0] map_wa;
  logic          map_wd;
  logic          stack_we;
  logic [IW-1:0] stack_wd;
  result_t       result_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_pages <= RST_RAM_PAGES;
      bios_base <= RST_BIOS_BASE;
      bios_top  <= RST_BIOS_TOP;
      kern_base <= RST_KERNEL_BASE;
      kern_top  <= RST_KERNEL_TOP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAM_PAGES:   ram_pages <= cfg_data;
        REG_BIOS_BASE:   bios_base <= cfg_data;
        REG_BIOS_TOP:    bios_top  <= cfg_data;
        REG_KERNEL_BASE: kern_base <= cfg_data;
        REG_KERNEL_TOP:  kern_top  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign page_in32 = 32'(item.page_number);
  assign page_idx  = IW'(page_in32);
  // page 0 and map entries at or past the last walk bound are not walked: read as free
  assign page_ok   = (page_in32 < MAX_PAGES) && (page_in32 != 32'd0) &&
                     (page_in32 < 32'(limit));
  assign ram32     = 32'(ram_pages);
  assign walk_lim  = (ram32 > MAX_PAGES) ? CW'(MAX_PAGES) : CW'(ram32);
  assign cur32     = 32'(cursor);
  assign walk_done = cur32 >= 32'(limit);
  assign reserved  = ((cur32 >= 32'(bios_base)) && (cur32 < 32'(bios_top))) ||
                     ((cur32 >= 32'(kern_base)) && (cur32 < 32'(kern_top)));
  assign empty     = (count == '0);
  assign used      = page_ok_q && map_rd;

  always_comb begin
    map_we   = 1'b0;
    map_wa   = page_q;
    map_wd   = 1'b0;
    stack_we = 1'b0;
    stack_wd = page_q;
    if (ctl.walk_step) begin
      map_we   = 1'b1;
      map_wa   = IW'(cursor);
      map_wd   = reserved;
      stack_we = !reserved;
      stack_wd = IW'(cursor);
    end else if (ctl.finish) begin
      case (op_q)
        OP_ALLOC: begin
          map_we = !empty;
          map_wa = stack_rd;
          map_wd = 1'b1;
        end
        OP_FREE: begin
          map_we   = used;
          stack_we = used;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (ctl.accept) begin
      map_rd <= map_mem[page_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[IW'(count)] <= stack_wd;
    end
    if (ctl.accept) begin
      stack_rd <= stack_mem[IW'(count - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_q      <= item.operation;
      page_q    <= page_idx;
      page_ok_q <= page_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
      limit  <= '0;
    end else if (ctl.accept && (item.operation == OP_INIT)) begin
      count  <= '0;
      cursor <= CW'(1);
      limit  <= walk_lim;
    end else if (ctl.walk_step) begin
      cursor <= cursor + 1'b1;
      if (!reserved) begin
        count <= count + 1'b1;
      end
    end else if (ctl.finish) begin
      if ((op_q == OP_ALLOC) && !empty) begin
        count <= count - 1'b1;
      end else if ((op_q == OP_FREE) && used) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_comb begin
    result_next.granted_page = '0;
    result_next.status       = ST_OK;
    case (op_q)
      OP_ALLOC: begin
        if (empty) begin
          result_next.status = ST_EMPTY;
        end else begin
          result_next.granted_page = PAGE_W'(32'(stack_rd));
        end
      end
      OP_FREE: begin
        if (!used) begin
          result_next.status = ST_NOT_USED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result <= result_next;
    end
  end

endmodule

// ===== sv/page_frame_allocator_unit.sv =====
// Allocate, free and unused codes: the start is taken in IDLE with a registered read of the
// free stack and the used map; FINISH updates them and registers the result and done. Busy
// holds off a new item until FINISH is left. Init: walks pages 1 to min(ram_pages, MAX_PAGES)-1,
// one page per cycle, strobe at end. Results cannot be stalled; each shows for one cycle on done.
// Synchronous reset clears control and the walk bound, so every page reads as not in use
// and the stack as empty until the first init; the memories need no clearing pass.
module page_frame_allocator_unit #(
  parameter int MAX_PAGES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pfa_pkg::item_t                 item,
  output logic                           done,
  output pfa_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfa_pkg::REG_W-1:0]      cfg_data
);
  import pfa_pkg::*;

  ctl_t ctl;
  logic walk_done;

  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .walk_done (walk_done),
    .busy      (busy),
    .ctl       (ctl)
  );

  pfa_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .walk_done (walk_done),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== sv/pfa_checker.sv =====
module pfa_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input pfa_pkg::item_t   item,
  input logic             done,
  input pfa_pkg::result_t result
);
  import pfa_pkg::*;

  // a result word ends the item: the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_short_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.operation != OP_INIT)) |=> ##1 done)
    else $error("allocate or free result missing two cycles after start");

  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result words in a row");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.granted_page == '0))
    else $error("page granted with an error status");

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (.*);
